// File: rtl/core/swsr_pkg.sv
// Shared types and constants for the single-wire sensor reader.
package swsr_pkg;

    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned FRAME_BYTES = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_HOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_HOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;

    localparam logic [HOLD_W-1:0] RST_LOW_HOLD  = 16'd18000;
    localparam logic [BYTE_W-1:0] RST_HIGH_HOLD = 8'd40;
    localparam logic [BYTE_W-1:0] RST_THRESHOLD = 8'd16;
    localparam logic [BYTE_W-1:0] RST_TIMEOUT   = 8'd255;

    localparam logic [7:0] MAX_TRANSITIONS = 8'd85;
    localparam logic [7:0] FIRST_DATA_EDGE = 8'd4;
    localparam logic [5:0] FRAME_BITS      = 6'd40;

    typedef struct packed {
        logic [HOLD_W-1:0] low_hold_ticks;
        logic [BYTE_W-1:0] high_hold_ticks;
        logic [BYTE_W-1:0] bit_threshold;
        logic [BYTE_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              drive_low;
        logic              drive_enable;
        logic              busy_res;
        logic              done_res;
        logic              reading_ok;
        logic [BYTE_W-1:0] humidity_whole;
        logic [BYTE_W-1:0] humidity_fraction;
        logic [BYTE_W-1:0] temperature_whole;
        logic [BYTE_W-1:0] temperature_fraction;
    } t_result;

endpackage

// File: rtl/core/swsr_cfg.sv
// Configuration register file for the sensor reader.
module swsr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swsr_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output swsr_pkg::t_cfg                 o_cfg
);

    swsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_hold_ticks  <= swsr_pkg::RST_LOW_HOLD;
            r_cfg.high_hold_ticks <= swsr_pkg::RST_HIGH_HOLD;
            r_cfg.bit_threshold   <= swsr_pkg::RST_THRESHOLD;
            r_cfg.timeout_ticks   <= swsr_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swsr_pkg::CFG_LOW_HOLD:  r_cfg.low_hold_ticks  <= i_cfg_data;
                swsr_pkg::CFG_HIGH_HOLD: r_cfg.high_hold_ticks <= i_cfg_data[7:0];
                swsr_pkg::CFG_THRESHOLD: r_cfg.bit_threshold   <= i_cfg_data[7:0];
                swsr_pkg::CFG_TIMEOUT:   r_cfg.timeout_ticks   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/swsr_core.sv
// Per-tick reader state machine: hold timing, run counting, bit capture, checksum.
module swsr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_start_req,
    input  logic                i_line_level,
    input  swsr_pkg::t_cfg      i_cfg,
    output swsr_pkg::t_result   o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_RECV
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [swsr_pkg::HOLD_W-1:0]     r_hold, n_hold;
    logic                            r_prev, n_prev;
    logic [7:0]                      r_run, n_run;
    logic [7:0]                      r_trans, n_trans;
    logic [5:0]                      r_bits, n_bits;
    logic [7:0]                      r_frame [swsr_pkg::FRAME_BYTES];
    logic [7:0]                      n_frame [swsr_pkg::FRAME_BYTES];
    logic [31:0]                     r_good, n_good;
    logic                            done;
    logic                            ok;
    logic                            finish;
    logic                            bit_val;
    logic [7:0]                      sum;

    always_comb begin
        n_phase = r_phase;
        n_hold  = r_hold;
        n_prev  = r_prev;
        n_run   = r_run;
        n_trans = r_trans;
        n_bits  = r_bits;
        n_frame = r_frame;
        finish  = 1'b0;
        bit_val = (r_run > i_cfg.bit_threshold);
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    for (int i = 0; i < swsr_pkg::FRAME_BYTES; i++) begin
                        n_frame[i] = 8'd0;
                    end
                    n_bits  = 6'd0;
                    n_trans = 8'd0;
                    n_run   = 8'd0;
                    n_prev  = 1'b1;
                    n_hold  = 16'd1;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (r_hold >= i_cfg.low_hold_ticks) begin
                    n_hold  = 16'd1;
                    n_phase = PH_HIGH;
                end else begin
                    n_hold = r_hold + 16'd1;
                end
            end
            PH_HIGH: begin
                if (r_hold >= {8'd0, i_cfg.high_hold_ticks}) begin
                    n_hold  = 16'd0;
                    n_run   = 8'd0;
                    n_trans = 8'd0;
                    n_prev  = 1'b1;
                    n_phase = PH_RECV;
                end else begin
                    n_hold = r_hold + 16'd1;
                end
            end
            PH_RECV: begin
                if (i_line_level == r_prev) begin
                    n_run = r_run + 8'd1;
                    if (n_run >= i_cfg.timeout_ticks) begin
                        finish = 1'b1;
                    end
                end else begin
                    if (r_trans >= swsr_pkg::FIRST_DATA_EDGE && !r_trans[0]
                            && r_bits < swsr_pkg::FRAME_BITS) begin
                        for (int i = 0; i < swsr_pkg::FRAME_BYTES; i++) begin
                            if (r_bits[5:3] == 3'(i)) begin
                                n_frame[i] = {r_frame[i][6:0], bit_val};
                            end
                        end
                        n_bits = r_bits + 6'd1;
                    end
                    n_prev  = i_line_level;
                    n_run   = 8'd0;
                    n_trans = r_trans + 8'd1;
                    if (n_trans >= swsr_pkg::MAX_TRANSITIONS) begin
                        finish = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // checksum over the frame as it stands after this beat
        sum    = n_frame[0] + n_frame[1] + n_frame[2] + n_frame[3];
        done   = finish;
        ok     = finish && (n_bits >= swsr_pkg::FRAME_BITS) && (n_frame[4] == sum);
        n_good = ok ? {n_frame[0], n_frame[1], n_frame[2], n_frame[3]} : r_good;
        if (finish) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hold  <= 16'd0;
            r_prev  <= 1'b1;
            r_run   <= 8'd0;
            r_trans <= 8'd0;
            r_bits  <= 6'd0;
            for (int i = 0; i < swsr_pkg::FRAME_BYTES; i++) begin
                r_frame[i] <= 8'd0;
            end
            r_good  <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_prev  <= n_prev;
            r_run   <= n_run;
            r_trans <= n_trans;
            r_bits  <= n_bits;
            r_frame <= n_frame;
            r_good  <= n_good;
        end
    end

    always_comb begin
        o_result.drive_low            = (n_phase == PH_LOW);
        o_result.drive_enable         = (n_phase == PH_LOW) || (n_phase == PH_HIGH);
        o_result.busy_res             = (n_phase != PH_IDLE);
        o_result.done_res             = done;
        o_result.reading_ok           = ok;
        o_result.humidity_whole       = n_good[31:24];
        o_result.humidity_fraction    = n_good[23:16];
        o_result.temperature_whole    = n_good[15:8];
        o_result.temperature_fraction = n_good[7:0];
    end

endmodule

// File: rtl/core/single_wire_sensor_reader_top.sv
// Top level of the single-wire sensor reader: config, tick core and result register.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------
//  tick in | i_in_valid / o_in_ready    | i_start_req, i_line_level
//  result  | o_out_valid / i_out_ready  | o_drive_low .. o_temperature_fraction
//  config  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One tick beat per cycle unless the output stalls; the core steps once per beat.
// The result of a beat shows in the output register the next cycle.
// Synchronous active-low reset: reader idle, state at defaults; r_out is not reset.
// A stalled result holds; a new tick is taken in the cycle the held result is taken.
module single_wire_sensor_reader_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_start_req,
    input  logic                           i_line_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_drive_low,
    output logic                           o_drive_enable,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_reading_ok,
    output logic [7:0]                     o_humidity_whole,
    output logic [7:0]                     o_humidity_fraction,
    output logic [7:0]                     o_temperature_whole,
    output logic [7:0]                     o_temperature_fraction,
    input  logic                           i_cfg_we,
    input  logic [swsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swsr_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    swsr_pkg::t_cfg    cfg;
    swsr_pkg::t_result n_out;
    swsr_pkg::t_result r_out;
    logic              r_out_valid;
    logic              accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    swsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swsr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_start_req  (i_start_req),
        .i_line_level (i_line_level),
        .i_cfg        (cfg),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_drive_low            = r_out.drive_low;
    assign o_drive_enable         = r_out.drive_enable;
    assign o_busy_res             = r_out.busy_res;
    assign o_done_res             = r_out.done_res;
    assign o_reading_ok           = r_out.reading_ok;
    assign o_humidity_whole       = r_out.humidity_whole;
    assign o_humidity_fraction    = r_out.humidity_fraction;
    assign o_temperature_whole    = r_out.temperature_whole;
    assign o_temperature_fraction = r_out.temperature_fraction;

endmodule

// File: rtl/core/swsr_checker.sv
// Port-level assertions for the sensor reader, bound to the top level.
module swsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_drive_low,
    input logic       o_drive_enable,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_reading_ok,
    input logic [7:0] o_humidity_whole
);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done beat shows reader still busy");

    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reading_ok |-> o_done_res)
        else $error("reading_ok without done");

    a_low_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_drive_enable && o_busy_res)
        else $error("drive_low while not driving or not busy");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_enable |-> o_busy_res)
        else $error("line driven outside a reading");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_done_res)
            && $stable(o_humidity_whole))
        else $error("stalled result beat changed");

endmodule

bind single_wire_sensor_reader_top swsr_checker u_swsr_checker (.*);
